// File: hdl/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

   localparam int MAX_COLS   = 128;
   localparam int MAX_ROWS   = 32;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int CELL_W     = 16;
   localparam int CELL_AW    = $clog2(CELL_COUNT);
   localparam int LIN_W      = CELL_AW + 1;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TILDE     = 8'h7E;

   localparam logic [2:0] CSR_COLUMNS    = 3'd0;
   localparam logic [2:0] CSR_ROWS       = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_COL = 3'd2;
   localparam logic [2:0] CSR_ORIGIN_ROW = 3'd3;
   localparam logic [2:0] CSR_DEFAULT_FG = 3'd4;
   localparam logic [2:0] CSR_DEFAULT_BG = 3'd5;

   typedef enum logic [2:0] {
      KIND_PUT_CURSOR   = 3'd0,
      KIND_PUT_CELL     = 3'd1,
      KIND_CLEAR_SCREEN = 3'd2,
      KIND_CLEAR_SPAN   = 3'd3,
      KIND_READ_CELL    = 3'd4
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_PUT,
      ST_NEWLINE,
      ST_COPY_LD,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_LASTROW,
      ST_SPAN_END,
      ST_FILL_LD,
      ST_FILL,
      ST_BS,
      ST_SCAN_LD,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_BS_ADDR,
      ST_BS_WR,
      ST_READ_LD,
      ST_READ_DATA,
      ST_DONE
   } state_type;

   // linear cell address request: a + b * columns
   typedef struct packed {
      logic [6:0] a;
      logic [5:0] b;
   } mac_req_type;

endpackage

`default_nettype wire

// File: hdl/tccw_ram.sv
`default_nettype none

module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hdl/tccw_mac.sv
`default_nettype none

module tccw_mac
   import tccw_pkg::*;
(
   input  wire logic              clock,
   input  wire mac_req_type       req,
   input  wire logic [7:0]        cols,
   output logic      [LIN_W-1:0]  res
);

   logic [LIN_W-1:0] res_ff;
   logic [LIN_W-1:0] res_in;

   assign res_in = LIN_W'(req.a) + LIN_W'(req.b) * LIN_W'(cols);

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// File: hdl/text_console_cell_writer.sv
`default_nettype none

// Channel  Dir  Handshake            Word
// req_     in   req_valid/req_ready  kind, character, colors, col/row, end_col/end_row
// rsp_     out  rsp_valid/rsp_ready  cursor, read cell, scrolled
// csr_     in   csr_we               csr_index, csr_wdata (no wait)
//
// One word at a time. Clears write one cell per cycle; scroll copies each cell through a
// read and a write state, then fills the last row; backspace row scans read and check each
// cell in turn. Cell address products all go through one shared multiply-add.
// Reset homes the cursor and loads the default geometry; the cell store is not cleared.
// A finished response waits in its own register, so the next word is taken meanwhile.

module text_console_cell_writer
   import tccw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_kind,
   input  wire logic [7:0] req_character,
   input  wire logic       req_use_given_colors,
   input  wire logic [3:0] req_fg_color,
   input  wire logic [3:0] req_bg_color,
   input  wire logic [6:0] req_col,
   input  wire logic [4:0] req_row,
   input  wire logic [6:0] req_end_col,
   input  wire logic [4:0] req_end_row,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [6:0] rsp_cursor_col,
   output logic      [4:0] rsp_cursor_row,
   output logic      [7:0] rsp_read_char,
   output logic      [3:0] rsp_read_fg,
   output logic      [3:0] rsp_read_bg,
   output logic            rsp_scrolled,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [7:0] columns_ff, columns_in;
   logic [5:0] rows_ff, rows_in;
   logic [6:0] ocol_ff, ocol_in;
   logic [4:0] orow_ff, orow_in;
   logic [3:0] dfg_ff, dfg_in;
   logic [3:0] dbg_ff, dbg_in;

   logic [6:0] cur_x_ff, cur_x_in;
   logic [4:0] cur_y_ff, cur_y_in;

   logic [2:0] kind_ff, kind_in;
   logic [7:0] char_ff, char_in;
   logic [3:0] fg_ff, fg_in;
   logic [3:0] bg_ff, bg_in;
   logic [6:0] col_ff, col_in;
   logic [4:0] row_ff, row_in;
   logic [6:0] ecol_ff, ecol_in;
   logic [4:0] erow_ff, erow_in;
   logic       ok_ff, ok_in;

   logic [LIN_W-1:0]  size_ff, size_in;
   logic [LIN_W-1:0]  addr_ff, addr_in;
   logic [LIN_W-1:0]  end_ff, end_in;
   logic [6:0]        cc_ff, cc_in;
   logic [4:0]        rr_ff, rr_in;
   logic [CELL_W-1:0] val_ff, val_in;
   logic [CELL_W-1:0] rd_ff, rd_in;
   logic              scr_ff, scr_in;

   logic              out_valid_ff, out_valid_in;
   logic [6:0]        out_col_ff, out_col_in;
   logic [4:0]        out_row_ff, out_row_in;
   logic [CELL_W-1:0] out_rd_ff, out_rd_in;
   logic              out_scr_ff, out_scr_in;

   logic [7:0] eff_cols;
   logic [5:0] eff_rows;
   logic [6:0] eff_ocol;
   logic [4:0] eff_orow;
   logic [6:0] cols_m1;
   logic [4:0] rows_m1;
   logic       printable;
   logic [7:0] nx_put;
   logic [5:0] ny_line;
   logic [5:0] orow_p1;
   logic [6:0] nx_bs;
   logic [LIN_W-1:0] copy_dst;

   mac_req_type      mac_req;
   logic [LIN_W-1:0] mac_res;

   logic               ram_we;
   logic [CELL_AW-1:0] ram_waddr;
   logic [CELL_W-1:0]  ram_wdata;
   logic [CELL_AW-1:0] ram_raddr;
   logic [CELL_W-1:0]  ram_rdata;

   tccw_mac u_mac (
      .clock (clock),
      .req   (mac_req),
      .cols  (eff_cols),
      .res   (mac_res)
   );

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      priority if (columns_ff == 8'd0) begin
         eff_cols = 8'd1;
      end else if (columns_ff > 8'(MAX_COLS)) begin
         eff_cols = 8'(MAX_COLS);
      end else begin
         eff_cols = columns_ff;
      end
      priority if (rows_ff == 6'd0) begin
         eff_rows = 6'd1;
      end else if (rows_ff > 6'(MAX_ROWS)) begin
         eff_rows = 6'(MAX_ROWS);
      end else begin
         eff_rows = rows_ff;
      end
   end

   assign cols_m1   = 7'(eff_cols - 8'd1);
   assign rows_m1   = 5'(eff_rows - 6'd1);
   assign eff_ocol  = ({1'b0, ocol_ff} < eff_cols) ? ocol_ff : cols_m1;
   assign eff_orow  = ({1'b0, orow_ff} < eff_rows) ? orow_ff : rows_m1;
   assign printable = (char_ff >= CHAR_SPACE) && (char_ff <= CHAR_TILDE);
   assign nx_put    = {1'b0, cur_x_ff} + 8'd1;
   assign ny_line   = {1'b0, cur_y_ff} + 6'd1;
   assign orow_p1   = {1'b0, eff_orow} + 6'd1;
   assign nx_bs     = cur_x_ff - 7'd1;
   assign copy_dst  = addr_ff - LIN_W'(eff_cols);

   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      ocol_in    = ocol_ff;
      orow_in    = orow_ff;
      dfg_in     = dfg_ff;
      dbg_in     = dbg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COLUMNS:    columns_in = csr_wdata;
            CSR_ROWS:       rows_in    = csr_wdata[5:0];
            CSR_ORIGIN_COL: ocol_in    = csr_wdata[6:0];
            CSR_ORIGIN_ROW: orow_in    = csr_wdata[4:0];
            CSR_DEFAULT_FG: dfg_in     = csr_wdata[3:0];
            CSR_DEFAULT_BG: dbg_in     = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      ecol_in      = ecol_ff;
      erow_in      = erow_ff;
      ok_in        = ok_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      cc_in        = cc_ff;
      rr_in        = rr_ff;
      val_in       = val_ff;
      rd_in        = rd_ff;
      scr_in       = scr_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_rd_in    = out_rd_ff;
      out_scr_in   = out_scr_ff;
      mac_req      = '{a: 7'd0, b: eff_rows};
      ram_we       = 1'b0;
      ram_waddr    = addr_ff[CELL_AW-1:0];
      ram_wdata    = val_ff;
      ram_raddr    = addr_ff[CELL_AW-1:0];
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in  = req_kind;
               char_in  = req_character;
               fg_in    = req_use_given_colors ? req_fg_color : dfg_ff;
               bg_in    = req_use_given_colors ? req_bg_color : dbg_ff;
               col_in   = req_col;
               row_in   = req_row;
               ecol_in  = req_end_col;
               erow_in  = req_end_row;
               rd_in    = '0;
               scr_in   = 1'b0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            size_in = mac_res;
            val_in  = {bg_ff, fg_ff, CHAR_NUL};
            if (kind_ff == KIND_PUT_CURSOR || kind_ff == KIND_PUT_CELL) begin
               priority if (printable) begin
                  if (kind_ff == KIND_PUT_CURSOR) begin
                     mac_req = '{a: cur_x_ff, b: {1'b0, cur_y_ff}};
                     ok_in   = ({1'b0, cur_x_ff} < eff_cols) && ({1'b0, cur_y_ff} < eff_rows);
                  end else begin
                     mac_req = '{a: col_ff, b: {1'b0, row_ff}};
                     ok_in   = ({1'b0, col_ff} < eff_cols) && ({1'b0, row_ff} < eff_rows);
                  end
                  state_in = ST_PUT;
               end else if (char_ff == CHAR_NEWLINE) begin
                  state_in = ST_NEWLINE;
               end else if (char_ff == CHAR_BACKSPACE) begin
                  state_in = ST_BS;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (kind_ff == KIND_CLEAR_SCREEN) begin
               end_in   = mac_res;
               mac_req  = '{a: eff_ocol, b: {1'b0, eff_orow}};
               cur_x_in = eff_ocol;
               cur_y_in = eff_orow;
               state_in = ST_FILL_LD;
            end else if (kind_ff == KIND_CLEAR_SPAN) begin
               mac_req  = '{a: ecol_ff, b: {1'b0, erow_ff}};
               state_in = ST_SPAN_END;
            end else if (kind_ff == KIND_READ_CELL) begin
               mac_req  = '{a: col_ff, b: {1'b0, row_ff}};
               ok_in    = ({1'b0, col_ff} < eff_cols) && ({1'b0, row_ff} < eff_rows);
               state_in = ST_READ_LD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PUT: begin
            ram_we    = ok_ff;
            ram_waddr = mac_res[CELL_AW-1:0];
            ram_wdata = {bg_ff, fg_ff, char_ff};
            if (kind_ff == KIND_PUT_CURSOR) begin
               if (nx_put >= eff_cols) begin
                  state_in = ST_NEWLINE;
               end else begin
                  cur_x_in = nx_put[6:0];
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_NEWLINE: begin
            cur_x_in = eff_ocol;
            if (ny_line >= eff_rows) begin
               scr_in   = 1'b1;
               cur_y_in = rows_m1;
               if (orow_p1 < eff_rows) begin
                  mac_req  = '{a: eff_ocol, b: orow_p1};
                  cc_in    = eff_ocol;
                  rr_in    = orow_p1[4:0];
                  state_in = ST_COPY_LD;
               end else begin
                  state_in = ST_LASTROW;
               end
            end else begin
               cur_y_in = ny_line[4:0];
               state_in = ST_DONE;
            end
         end
         ST_COPY_LD: begin
            addr_in  = mac_res;
            state_in = ST_COPY_RD;
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            ram_we    = 1'b1;
            ram_waddr = copy_dst[CELL_AW-1:0];
            ram_wdata = ram_rdata;
            if (cc_ff == cols_m1) begin
               if (rr_ff == rows_m1) begin
                  state_in = ST_LASTROW;
               end else begin
                  rr_in    = rr_ff + 5'd1;
                  cc_in    = eff_ocol;
                  addr_in  = addr_ff + LIN_W'(eff_ocol) + LIN_W'(1);
                  state_in = ST_COPY_RD;
               end
            end else begin
               cc_in    = cc_ff + 7'd1;
               addr_in  = addr_ff + LIN_W'(1);
               state_in = ST_COPY_RD;
            end
         end
         ST_LASTROW: begin
            mac_req  = '{a: eff_ocol, b: {1'b0, rows_m1}};
            end_in   = size_ff;
            val_in   = {dbg_ff, dfg_ff, CHAR_NUL};
            state_in = ST_FILL_LD;
         end
         ST_SPAN_END: begin
            end_in   = (mac_res < size_ff) ? mac_res : size_ff;
            mac_req  = '{a: col_ff, b: {1'b0, row_ff}};
            state_in = ST_FILL_LD;
         end
         ST_FILL_LD: begin
            addr_in  = mac_res;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            if (addr_ff < end_ff) begin
               ram_we  = 1'b1;
               addr_in = addr_ff + LIN_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_BS: begin
            if (cur_x_ff == 7'd0) begin
               if (cur_y_ff != 5'd0) begin
                  cur_y_in = cur_y_ff - 5'd1;
                  cc_in    = 7'd0;
                  mac_req  = '{a: 7'd0, b: {1'b0, cur_y_ff - 5'd1}};
                  state_in = ST_SCAN_LD;
               end else begin
                  state_in = ST_BS_ADDR;
               end
            end else begin
               cur_x_in = ({1'b0, nx_bs} >= eff_cols) ? cols_m1 : nx_bs;
               state_in = ST_BS_ADDR;
            end
         end
         ST_SCAN_LD: begin
            addr_in  = mac_res;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            priority if (addr_ff >= size_ff || ram_rdata[7:0] == CHAR_NUL) begin
               cur_x_in = cc_ff;
               state_in = ST_BS_ADDR;
            end else if (cc_ff == cols_m1) begin
               cur_x_in = cols_m1;
               state_in = ST_BS_ADDR;
            end else begin
               cc_in    = cc_ff + 7'd1;
               addr_in  = addr_ff + LIN_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_BS_ADDR: begin
            mac_req  = '{a: cur_x_ff, b: {1'b0, cur_y_ff}};
            state_in = ST_BS_WR;
         end
         ST_BS_WR: begin
            ram_we    = (mac_res < size_ff);
            ram_waddr = mac_res[CELL_AW-1:0];
            ram_wdata = {dbg_ff, dfg_ff, CHAR_NUL};
            state_in  = ST_DONE;
         end
         ST_READ_LD: begin
            ram_raddr = mac_res[CELL_AW-1:0];
            state_in  = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            rd_in    = ok_ff ? ram_rdata : '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_col_in   = cur_x_ff;
               out_row_in   = cur_y_ff;
               out_rd_in    = rd_ff;
               out_scr_in   = scr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         columns_ff   <= 8'd80;
         rows_ff      <= 6'd25;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         dfg_ff       <= 4'd15;
         dbg_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         dfg_ff       <= dfg_in;
         dbg_ff       <= dbg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      char_ff    <= char_in;
      fg_ff      <= fg_in;
      bg_ff      <= bg_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      ecol_ff    <= ecol_in;
      erow_ff    <= erow_in;
      ok_ff      <= ok_in;
      size_ff    <= size_in;
      addr_ff    <= addr_in;
      end_ff     <= end_in;
      cc_ff      <= cc_in;
      rr_ff      <= rr_in;
      val_ff     <= val_in;
      rd_ff      <= rd_in;
      scr_ff     <= scr_in;
      out_col_ff <= out_col_in;
      out_row_ff <= out_row_in;
      out_rd_ff  <= out_rd_in;
      out_scr_ff <= out_scr_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_cursor_col = out_col_ff;
   assign rsp_cursor_row = out_row_ff;
   assign rsp_read_char  = out_rd_ff[7:0];
   assign rsp_read_fg    = out_rd_ff[11:8];
   assign rsp_read_bg    = out_rd_ff[15:12];
   assign rsp_scrolled   = out_scr_ff;

endmodule

`default_nettype wire
